/* rtl/core/pmct_pkg.sv */
// Shared types, constants and segment tables of the power meter calibrate-and-trip block.
`default_nettype none
package pmct_pkg;

	// Field widths of the sample and result channels.
	localparam int CUR_W    = 17;
	localparam int VOLT_W   = 16;
	localparam int PWR_W    = 21;
	localparam int CCUR_W   = 18;
	localparam int CVOLT_W  = 17;
	localparam int ENERGY_W = 48;
	localparam int DUTY_W   = 7;
	localparam int SEC_W    = 32;
	localparam int LIMIT_W  = 16;
	localparam int VOL_W    = 10;

	// Calibration segments and packed offsets.
	localparam int NUM_SEGS = 6;
	localparam int OFFSET_W = 10;
	localparam int CFG_W    = NUM_SEGS * OFFSET_W;
	localparam int SEG_W    = 3;
	localparam logic [SEG_W-1:0] SEG_NONE = SEG_W'(NUM_SEGS);

	// Offset times sample, its magnitude, and the quotient after the reference divide.
	localparam int PROD_W      = OFFSET_W + CUR_W;
	localparam int MAG_W       = PROD_W - 1;
	localparam int RECIP_SHIFT = 42;
	localparam int RECIP_W     = 33;
	localparam int RMUL_W      = MAG_W + RECIP_W;
	localparam int QUO_W       = RMUL_W - RECIP_SHIFT;
	localparam int SUM_W       = CCUR_W + 1;

	localparam logic signed [CUR_W-1:0] CUR_BOUND [NUM_SEGS] = '{
		17'sd1500, 17'sd3000, 17'sd7500, 17'sd15000, 17'sd30000, 17'sd50000
	};
	localparam logic [VOLT_W-1:0] VOLT_BOUND [NUM_SEGS] = '{
		16'd7000, 16'd13000, 16'd18000, 16'd23000, 16'd28000, 16'd33000
	};
	localparam longint unsigned CUR_REF [NUM_SEGS] = '{
		64'd1000, 64'd2000, 64'd5000, 64'd10000, 64'd20000, 64'd50000
	};
	localparam longint unsigned VOLT_REF [NUM_SEGS] = '{
		64'd5000, 64'd10000, 64'd15000, 64'd20000, 64'd25000, 64'd30000
	};

	// Rounded-up reciprocals scaled by 2^RECIP_SHIFT; exact floor division for
	// every magnitude below 2^MAG_W. Unused segment codes hold zero.
	localparam logic [RECIP_W-1:0] CUR_RECIP [1 << SEG_W] = '{
		RECIP_W'(((64'd1 << RECIP_SHIFT) + CUR_REF[0] - 64'd1) / CUR_REF[0]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + CUR_REF[1] - 64'd1) / CUR_REF[1]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + CUR_REF[2] - 64'd1) / CUR_REF[2]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + CUR_REF[3] - 64'd1) / CUR_REF[3]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + CUR_REF[4] - 64'd1) / CUR_REF[4]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + CUR_REF[5] - 64'd1) / CUR_REF[5]),
		RECIP_W'(0),
		RECIP_W'(0)
	};
	localparam logic [RECIP_W-1:0] VOLT_RECIP [1 << SEG_W] = '{
		RECIP_W'(((64'd1 << RECIP_SHIFT) + VOLT_REF[0] - 64'd1) / VOLT_REF[0]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + VOLT_REF[1] - 64'd1) / VOLT_REF[1]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + VOLT_REF[2] - 64'd1) / VOLT_REF[2]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + VOLT_REF[3] - 64'd1) / VOLT_REF[3]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + VOLT_REF[4] - 64'd1) / VOLT_REF[4]),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + VOLT_REF[5] - 64'd1) / VOLT_REF[5]),
		RECIP_W'(0),
		RECIP_W'(0)
	};

	// Saturation bounds of the corrected values.
	localparam logic signed [SUM_W-1:0] CUR_MIN_S  = -(SUM_W'(1) <<< (CCUR_W - 1));
	localparam logic signed [SUM_W-1:0] CUR_MAX_S  = (SUM_W'(1) <<< (CCUR_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] VOLT_MAX_S = (SUM_W'(1) <<< CVOLT_W) - SUM_W'(1);
	localparam logic signed [CCUR_W-1:0] PEAK_RESET  = {1'b1, {(CCUR_W-1){1'b0}}};
	localparam logic signed [CCUR_W-1:0] LEAST_RESET = {1'b0, {(CCUR_W-1){1'b1}}};

	// Buzzer duty is volume / 10, taken as volume * 205 >> 11.
	localparam int DUTY_RECIP_W = 8;
	localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP = 8'd205;
	localparam int DUTY_SHIFT  = 11;
	localparam int DUTY_PROD_W = VOL_W + DUTY_RECIP_W;
	localparam logic [VOL_W-1:0] BUZZER_VOLUME_RESET = 10'd500;

	// Tick and second counting.
	localparam int TICKS_PER_SECOND = 100;
	localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
	localparam logic [TICK_W:0] TICKS_END = (TICK_W + 1)'(TICKS_PER_SECOND);

	// Queue between the front and back.
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CURRENT_OFFSETS    = 3'd0,
		REG_VOLTAGE_OFFSETS    = 3'd1,
		REG_UNDERVOLTAGE_LIMIT = 3'd2,
		REG_OVERCURRENT_LIMIT  = 3'd3,
		REG_BUZZER_VOLUME      = 3'd4
	} cfg_reg_t;

	// One classified tick as it waits in the queue.
	typedef struct packed {
		logic signed [CUR_W-1:0] cur_x;
		logic                    cur_neg;
		logic [MAG_W-1:0]        cur_mag;
		logic [SEG_W-1:0]        cur_seg;
		logic [VOLT_W-1:0]       volt_x;
		logic                    volt_neg;
		logic [MAG_W-1:0]        volt_mag;
		logic [SEG_W-1:0]        volt_seg;
		logic [PWR_W-1:0]        power;
		logic                    clear_trip;
	} item_t;

	// Trip configuration seen by the back.
	typedef struct packed {
		logic [LIMIT_W-1:0] undervoltage;
		logic [LIMIT_W-1:0] overcurrent;
		logic [VOL_W-1:0]   volume;
	} limits_t;

endpackage
`default_nettype wire

/* rtl/core/pmct_front.sv */
// Front: picks the calibration segment of each sample and forms offset times sample.
`default_nettype none
module pmct_front (
	input  wire logic signed [pmct_pkg::CUR_W-1:0]  current_sample,
	input  wire logic [pmct_pkg::VOLT_W-1:0]        voltage_sample,
	input  wire logic [pmct_pkg::PWR_W-1:0]         power_sample,
	input  wire logic                               clear_trip,
	input  wire logic [pmct_pkg::CFG_W-1:0]         current_offsets,
	input  wire logic [pmct_pkg::CFG_W-1:0]         voltage_offsets,
	output pmct_pkg::item_t                         item
);

	logic [pmct_pkg::SEG_W-1:0]           cur_seg;
	logic [pmct_pkg::SEG_W-1:0]           volt_seg;
	logic signed [pmct_pkg::OFFSET_W-1:0] cur_off;
	logic signed [pmct_pkg::OFFSET_W-1:0] volt_off;
	logic signed [pmct_pkg::PROD_W-1:0]   cur_prod;
	logic signed [pmct_pkg::PROD_W-1:0]   volt_prod;
	logic signed [pmct_pkg::CUR_W-1:0]    volt_x_s;
	logic [pmct_pkg::PROD_W-1:0]          cur_abs;
	logic [pmct_pkg::PROD_W-1:0]          volt_abs;

	// The lowest segment whose bound lies above the sample wins.
	always_comb begin
		cur_seg  = pmct_pkg::SEG_NONE;
		volt_seg = pmct_pkg::SEG_NONE;
		for (int s = pmct_pkg::NUM_SEGS - 1; s >= 0; s--) begin
			if (current_sample < pmct_pkg::CUR_BOUND[s]) begin
				cur_seg = pmct_pkg::SEG_W'(s);
			end
			if (voltage_sample < pmct_pkg::VOLT_BOUND[s]) begin
				volt_seg = pmct_pkg::SEG_W'(s);
			end
		end
	end

	// Samples at or above the last bound pass through with a zero offset.
	always_comb begin
		cur_off  = '0;
		volt_off = '0;
		for (int s = 0; s < pmct_pkg::NUM_SEGS; s++) begin
			if (cur_seg == pmct_pkg::SEG_W'(s)) begin
				cur_off = current_offsets[s*pmct_pkg::OFFSET_W +: pmct_pkg::OFFSET_W];
			end
			if (volt_seg == pmct_pkg::SEG_W'(s)) begin
				volt_off = voltage_offsets[s*pmct_pkg::OFFSET_W +: pmct_pkg::OFFSET_W];
			end
		end
	end

	assign volt_x_s  = $signed({1'b0, voltage_sample});
	assign cur_prod  = cur_off * current_sample;
	assign volt_prod = volt_off * volt_x_s;
	assign cur_abs   = cur_prod[pmct_pkg::PROD_W-1] ? (~cur_prod + 1'b1) : cur_prod;
	assign volt_abs  = volt_prod[pmct_pkg::PROD_W-1] ? (~volt_prod + 1'b1) : volt_prod;

	always_comb begin
		item.cur_x      = current_sample;
		item.cur_neg    = cur_prod[pmct_pkg::PROD_W-1];
		item.cur_mag    = cur_abs[pmct_pkg::MAG_W-1:0];
		item.cur_seg    = cur_seg;
		item.volt_x     = voltage_sample;
		item.volt_neg   = volt_prod[pmct_pkg::PROD_W-1];
		item.volt_mag   = volt_abs[pmct_pkg::MAG_W-1:0];
		item.volt_seg   = volt_seg;
		item.power      = power_sample;
		item.clear_trip = clear_trip;
	end

endmodule
`default_nettype wire

/* rtl/core/pmct_fifo.sv */
// Short queue that decouples the front from the back.
`default_nettype none
module pmct_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  pmct_pkg::item_t      push_item,
	output logic                 full,
	input  wire logic            pop,
	output pmct_pkg::item_t      pop_item,
	output logic                 not_empty
);

	pmct_pkg::item_t             entry_q [pmct_pkg::FIFO_DEPTH];
	logic [pmct_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [pmct_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [pmct_pkg::CNT_W-1:0]  count_q;

	assign full      = (count_q == pmct_pkg::CNT_W'(pmct_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pmct_pkg::PTR_W'(pmct_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pmct_pkg::PTR_W'(pmct_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/pmct_back.sv */
// Back: reference divide, saturation, energy, trip latch, extremes and seconds.
`default_nettype none
module pmct_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	input  pmct_pkg::item_t                          item,
	output logic                                     item_pop,
	input  pmct_pkg::limits_t                        limits,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [pmct_pkg::CCUR_W-1:0]       corrected_current,
	output logic [pmct_pkg::CVOLT_W-1:0]             corrected_voltage,
	output logic [pmct_pkg::ENERGY_W-1:0]            energy_total,
	output logic                                     load_enable,
	output logic                                     trip_now,
	output logic [pmct_pkg::DUTY_W-1:0]              buzzer_duty,
	output logic signed [pmct_pkg::CCUR_W-1:0]       peak_current,
	output logic signed [pmct_pkg::CCUR_W-1:0]       least_current,
	output logic [pmct_pkg::SEC_W-1:0]               elapsed_seconds
);

	// Stage 1: quotients.
	logic                                 valid_s1;
	logic signed [pmct_pkg::CUR_W-1:0]    cur_x_s1;
	logic signed [pmct_pkg::CCUR_W-1:0]   cur_q_s1;
	logic [pmct_pkg::VOLT_W-1:0]          volt_x_s1;
	logic signed [pmct_pkg::CCUR_W-1:0]   volt_q_s1;
	logic [pmct_pkg::PWR_W-1:0]           power_s1;
	logic                                 clear_s1;

	// Stage 2: result register.
	logic                                 valid_s2;
	logic signed [pmct_pkg::CCUR_W-1:0]   cur_s2;
	logic [pmct_pkg::CVOLT_W-1:0]         volt_s2;
	logic                                 trip_s2;

	// Running state.
	logic [pmct_pkg::ENERGY_W-1:0]        energy_q;
	logic signed [pmct_pkg::CCUR_W-1:0]   peak_q;
	logic signed [pmct_pkg::CCUR_W-1:0]   least_q;
	logic [pmct_pkg::TICK_W-1:0]          tick_q;
	logic [pmct_pkg::SEC_W-1:0]           seconds_q;
	logic                                 latch_q;
	logic [pmct_pkg::DUTY_W-1:0]          duty_q;

	logic                                 out_ready;
	logic                                 ready_s1;
	logic                                 advance;
	logic [pmct_pkg::RMUL_W-1:0]          cur_rmul;
	logic [pmct_pkg::RMUL_W-1:0]          volt_rmul;
	logic signed [pmct_pkg::CCUR_W-1:0]   cur_qpos;
	logic signed [pmct_pkg::CCUR_W-1:0]   volt_qpos;
	logic signed [pmct_pkg::SUM_W-1:0]    cur_sum;
	logic signed [pmct_pkg::SUM_W-1:0]    volt_sum;
	logic signed [pmct_pkg::CCUR_W-1:0]   cur_sat;
	logic [pmct_pkg::CVOLT_W-1:0]         volt_sat;
	logic                                 trip;
	logic [pmct_pkg::ENERGY_W:0]          energy_sum;
	logic [pmct_pkg::DUTY_PROD_W-1:0]     duty_prod;
	logic [pmct_pkg::TICK_W:0]            tick_next;

	assign out_ready = !valid_s2 || !out_stall;
	assign ready_s1  = !valid_s1 || out_ready;
	assign item_pop  = item_valid && ready_s1;
	assign advance   = valid_s1 && out_ready;

	// Division by the segment reference as a multiply by its reciprocal.
	assign cur_rmul  = pmct_pkg::RMUL_W'(item.cur_mag) *
		pmct_pkg::RMUL_W'(pmct_pkg::CUR_RECIP[item.cur_seg]);
	assign volt_rmul = pmct_pkg::RMUL_W'(item.volt_mag) *
		pmct_pkg::RMUL_W'(pmct_pkg::VOLT_RECIP[item.volt_seg]);
	assign cur_qpos  = $signed({1'b0, cur_rmul[pmct_pkg::RMUL_W-1:pmct_pkg::RECIP_SHIFT]});
	assign volt_qpos = $signed({1'b0, volt_rmul[pmct_pkg::RMUL_W-1:pmct_pkg::RECIP_SHIFT]});

	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_x_s1  <= item.cur_x;
			cur_q_s1  <= item.cur_neg ? -cur_qpos : cur_qpos;
			volt_x_s1 <= item.volt_x;
			volt_q_s1 <= item.volt_neg ? -volt_qpos : volt_qpos;
			power_s1  <= item.power;
			clear_s1  <= item.clear_trip;
		end
	end

	// Stage 2 arithmetic: correction, saturation and the limit checks.
	assign cur_sum  = pmct_pkg::SUM_W'(cur_x_s1) + pmct_pkg::SUM_W'(cur_q_s1);
	assign volt_sum = $signed({3'b000, volt_x_s1}) + pmct_pkg::SUM_W'(volt_q_s1);

	always_comb begin
		if (cur_sum < pmct_pkg::CUR_MIN_S) begin
			cur_sat = pmct_pkg::CUR_MIN_S[pmct_pkg::CCUR_W-1:0];
		end else if (cur_sum > pmct_pkg::CUR_MAX_S) begin
			cur_sat = pmct_pkg::CUR_MAX_S[pmct_pkg::CCUR_W-1:0];
		end else begin
			cur_sat = cur_sum[pmct_pkg::CCUR_W-1:0];
		end
		if (volt_sum[pmct_pkg::SUM_W-1]) begin
			volt_sat = '0;
		end else if (volt_sum > pmct_pkg::VOLT_MAX_S) begin
			volt_sat = pmct_pkg::VOLT_MAX_S[pmct_pkg::CVOLT_W-1:0];
		end else begin
			volt_sat = volt_sum[pmct_pkg::CVOLT_W-1:0];
		end
	end

	assign trip = ((limits.undervoltage != '0) &&
			({1'b0, limits.undervoltage} > volt_sat)) ||
		((limits.overcurrent != '0) &&
			(cur_sat > $signed({2'b00, limits.overcurrent})));

	assign energy_sum = {1'b0, energy_q} + (pmct_pkg::ENERGY_W + 1)'(power_s1);
	assign duty_prod  = pmct_pkg::DUTY_PROD_W'(limits.volume) *
		pmct_pkg::DUTY_PROD_W'(pmct_pkg::DUTY_RECIP);
	assign tick_next  = {1'b0, tick_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (advance) begin
			cur_s2  <= cur_sat;
			volt_s2 <= volt_sat;
			trip_s2 <= trip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			energy_q  <= '0;
			peak_q    <= pmct_pkg::PEAK_RESET;
			least_q   <= pmct_pkg::LEAST_RESET;
			tick_q    <= '0;
			seconds_q <= '0;
			latch_q   <= 1'b0;
			duty_q    <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= item_valid;
			end
			if (out_ready) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				energy_q <= energy_sum[pmct_pkg::ENERGY_W] ? '1 :
					energy_sum[pmct_pkg::ENERGY_W-1:0];
				if (cur_sat > peak_q) begin
					peak_q <= cur_sat;
				end
				if (cur_sat < least_q) begin
					least_q <= cur_sat;
				end
				if (tick_next >= pmct_pkg::TICKS_END) begin
					tick_q    <= '0;
					seconds_q <= seconds_q + 1'b1;
				end else begin
					tick_q <= tick_next[pmct_pkg::TICK_W-1:0];
				end
				// A clear on this tick acts before the new limit check.
				latch_q <= (latch_q && !clear_s1) || trip;
				if (trip) begin
					duty_q <= duty_prod[pmct_pkg::DUTY_SHIFT +: pmct_pkg::DUTY_W];
				end
			end
		end
	end

	assign out_valid         = valid_s2;
	assign corrected_current = cur_s2;
	assign corrected_voltage = volt_s2;
	assign energy_total      = energy_q;
	assign load_enable       = !latch_q;
	assign trip_now          = trip_s2;
	assign buzzer_duty       = duty_q;
	assign peak_current      = peak_q;
	assign least_current     = least_q;
	assign elapsed_seconds   = seconds_q;

endmodule
`default_nettype wire

/* rtl/core/power_meter_calibrate_and_trip.sv */
// Top level of the power meter calibrate-and-trip block: configuration registers and wiring.
`default_nettype none
// Takes one measurement tick per transfer and returns one result per tick, in order. A tick
// can be taken in every cycle while the queue is not full. The queue is written at the input
// transfer edge, and the result then passes the divide stage and the result register. It is
// taken at an edge where the output side does not stall. The
// front forms offset times sample in one multiplier per channel, a two-entry queue follows,
// and the back divides by the segment reference with a reciprocal multiplier, then
// saturates and updates energy, trip latch, extremes and seconds in the result stage.
// Configuration writes take effect at once and are meant to be made while no tick is in
// flight. The load switch output and duty reflect the state after the tick just returned.
module power_meter_calibrate_and_trip (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pmct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pmct_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [pmct_pkg::CUR_W-1:0]   current_sample,
	input  wire logic [pmct_pkg::VOLT_W-1:0]         voltage_sample,
	input  wire logic [pmct_pkg::PWR_W-1:0]          power_sample,
	input  wire logic                                clear_trip,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [pmct_pkg::CCUR_W-1:0]       corrected_current,
	output logic [pmct_pkg::CVOLT_W-1:0]             corrected_voltage,
	output logic [pmct_pkg::ENERGY_W-1:0]            energy_total,
	output logic                                     load_enable,
	output logic                                     trip_now,
	output logic [pmct_pkg::DUTY_W-1:0]              buzzer_duty,
	output logic signed [pmct_pkg::CCUR_W-1:0]       peak_current,
	output logic signed [pmct_pkg::CCUR_W-1:0]       least_current,
	output logic [pmct_pkg::SEC_W-1:0]               elapsed_seconds
);

	logic [pmct_pkg::CFG_W-1:0]   current_offsets_q;
	logic [pmct_pkg::CFG_W-1:0]   voltage_offsets_q;
	logic [pmct_pkg::LIMIT_W-1:0] undervoltage_q;
	logic [pmct_pkg::LIMIT_W-1:0] overcurrent_q;
	logic [pmct_pkg::VOL_W-1:0]   volume_q;

	pmct_pkg::item_t   front_item;
	pmct_pkg::item_t   queue_item;
	pmct_pkg::limits_t limits;
	logic              push;
	logic              fifo_full;
	logic              fifo_not_empty;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_offsets_q <= '0;
			voltage_offsets_q <= '0;
			undervoltage_q    <= '0;
			overcurrent_q     <= '0;
			volume_q          <= pmct_pkg::BUZZER_VOLUME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pmct_pkg::REG_CURRENT_OFFSETS: begin
					current_offsets_q <= cfg_data;
				end
				pmct_pkg::REG_VOLTAGE_OFFSETS: begin
					voltage_offsets_q <= cfg_data;
				end
				pmct_pkg::REG_UNDERVOLTAGE_LIMIT: begin
					undervoltage_q <= cfg_data[pmct_pkg::LIMIT_W-1:0];
				end
				pmct_pkg::REG_OVERCURRENT_LIMIT: begin
					overcurrent_q <= cfg_data[pmct_pkg::LIMIT_W-1:0];
				end
				pmct_pkg::REG_BUZZER_VOLUME: begin
					volume_q <= cfg_data[pmct_pkg::VOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign limits.undervoltage = undervoltage_q;
	assign limits.overcurrent  = overcurrent_q;
	assign limits.volume       = volume_q;

	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	pmct_front u_front (
		.current_sample  (current_sample),
		.voltage_sample  (voltage_sample),
		.power_sample    (power_sample),
		.clear_trip      (clear_trip),
		.current_offsets (current_offsets_q),
		.voltage_offsets (voltage_offsets_q),
		.item            (front_item)
	);

	pmct_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (fifo_full),
		.pop       (pop),
		.pop_item  (queue_item),
		.not_empty (fifo_not_empty)
	);

	pmct_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (fifo_not_empty),
		.item              (queue_item),
		.item_pop          (pop),
		.limits            (limits),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.corrected_current (corrected_current),
		.corrected_voltage (corrected_voltage),
		.energy_total      (energy_total),
		.load_enable       (load_enable),
		.trip_now          (trip_now),
		.buzzer_duty       (buzzer_duty),
		.peak_current      (peak_current),
		.least_current     (least_current),
		.elapsed_seconds   (elapsed_seconds)
	);

	// A tick that trips always leaves the load switched off.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trip_now |-> !load_enable)
		else $error("trip reported with load still enabled");

	// Once any tick has been returned, the least current never exceeds the peak.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> least_current <= peak_current)
		else $error("least current above peak current");

	// Energy never decreases from one returned tick to the next.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid || energy_total >= $past(energy_total))
		else $error("energy total decreased");

	// The queue is written only when it has room and read only when it holds a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !fifo_full) and (pop |-> fifo_not_empty))
		else $error("queue overrun or underrun");

endmodule
`default_nettype wire
